[design/actr_pkg.sv]
package actr_pkg;

   // Block and field widths
   localparam int unsigned BLOCK_BITS  = 128;
   localparam int unsigned BLOCK_BYTES = 16;
   localparam int unsigned NUM_ROUNDS  = 10;
   localparam int unsigned CTR_BITS    = 32;
   localparam int unsigned COUNT_BITS  = 5;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CTR_BITS-1:0]   CTR_START = 32'h0000_0001;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 5'd16;
   localparam logic [7:0]            RCON_FIRST = 8'h01;

   typedef logic [BLOCK_BITS-1:0] block_type;

   // Register map of the csr channel
   typedef enum logic [1:0] {
      CSR_KEY_HIGH   = 2'd0,
      CSR_KEY_LOW    = 2'd1,
      CSR_NONCE_HIGH = 2'd2,
      CSR_NONCE_LOW  = 2'd3
   } csr_idx_type;

   // Key schedule status toward the datapath
   typedef struct packed {
      logic busy;
   } ks_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // GF(2^8) doubling
   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // One cipher round: SubBytes, ShiftRows, MixColumns (skipped on last), AddRoundKey.
   // Byte i of a block sits at bits [127-8i -: 8].
   function automatic block_type aes_round(input block_type s, input block_type rk,
                                           input logic last);
      logic [7:0] a [16];
      logic [7:0] t [16];
      logic [7:0] x;
      block_type  r;
      for (int i = 0; i < 16; i++) begin
         a[i] = s[127-8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            t[k+4*c] = SBOX[a[k+4*((c+k)%4)]];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            a[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
            a[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
            a[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
            a[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
         end
      end else begin
         for (int i = 0; i < 16; i++) begin
            a[i] = t[i];
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127-8*i -: 8] = a[i];
      end
      return r ^ rk;
   endfunction

endpackage

[design/actr_if.sv]
interface actr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic [4:0]  byte_count;
   logic        restart;
   modport source(output valid, block_high, block_low, byte_count, restart, input ready);
   modport sink(input valid, block_high, block_low, byte_count, restart, output ready);
endinterface

interface actr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source(output valid, result_high, result_low, input ready);
   modport sink(input valid, result_high, result_low, output ready);
endinterface

interface actr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[design/actr_keysched.sv]
module actr_keysched (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  actr_pkg::block_type     key,
   output actr_pkg::block_type     round_keys [actr_pkg::NUM_ROUNDS+1],
   output actr_pkg::ks_status_type status
);
   import actr_pkg::*;

   logic [3:0] step_ff, step_in;
   logic       busy_ff, busy_in;
   logic [7:0] rcon_ff, rcon_in;
   block_type  prev_ff, prev_in;
   block_type  rk_ff [NUM_ROUNDS+1];
   block_type  next_key;

   // Next round key from the previous one
   function automatic block_type key_next(input block_type p, input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] w0, w1, w2, w3;
      t  = {SBOX[p[23:16]] ^ rc, SBOX[p[15:8]], SBOX[p[7:0]], SBOX[p[31:24]]};
      w0 = p[127:96] ^ t;
      w1 = p[95:64] ^ w0;
      w2 = p[63:32] ^ w1;
      w3 = p[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   assign next_key = key_next(prev_ff, rcon_ff);

   // Step sequencer: one round key per cycle, rerun after reset and every key write
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      rcon_in = rcon_ff;
      prev_in = prev_ff;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 4'd0) begin
            prev_in = key;
            rcon_in = RCON_FIRST;
         end else begin
            prev_in = next_key;
            rcon_in = xtime(rcon_ff);
         end
         if (step_ff == 4'(NUM_ROUNDS)) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b1;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rcon_ff <= rcon_in;
      prev_ff <= prev_in;
      if (busy_ff && !start) begin
         rk_ff[step_ff] <= (step_ff == 4'd0) ? key : next_key;
      end
   end

   assign round_keys  = rk_ff;
   assign status.busy = busy_ff;

`ifndef NO_ASSERTIONS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 4'(NUM_ROUNDS))
      else $error("key schedule step out of range");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && step_ff == 4'd0)
      else $error("key write did not restart the schedule");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == 4'(NUM_ROUNDS) && !start) |=> !busy_ff)
      else $error("key schedule did not finish");
`endif
endmodule

[design/aes128_ctr_stream_cipher_core.sv]
// AES-128 counter-mode cipher, one 16-byte beat per cycle.
// A result is registered: each beat passes the round registers, then the output register.
// Throughput: one beat per cycle; the round pipeline stalls as a whole when rsp is held.
// After reset, and after any key write, req.ready stays low while the key schedule unit
// expands the round keys. Reset clears key and nonce to zero, counter to 1.
module aes128_ctr_stream_cipher_core (
   input logic       clock,
   input logic       reset,
   actr_req_if.sink  req_chan,
   actr_rsp_if.source rsp_chan,
   actr_csr_if.sink  csr_chan
);
   import actr_pkg::*;

   logic [63:0]         key_high_ff, key_low_ff, nonce_high_ff;
   logic [31:0]         nonce_low_ff;
   logic [CTR_BITS-1:0] ctr_ff, ctr_in, ctr_sel;
   block_type           round_keys [NUM_ROUNDS+1];
   ks_status_type       ks_status;
   logic                key_write, csr_fire, req_fire, adv;
   logic [COUNT_BITS-1:0] cnt_sat;

   logic                vld_ff [NUM_ROUNDS];
   block_type           st_ff  [NUM_ROUNDS];
   block_type           dat_ff [NUM_ROUNDS];
   logic [COUNT_BITS-1:0] cnt_ff [NUM_ROUNDS];
   logic                out_vld_ff;
   block_type           out_ff, out_in;
   block_type           last_ks;

   // Configuration registers
   assign csr_chan.ready = 1'b1;
   assign csr_fire  = csr_chan.valid;
   assign key_write = csr_fire && (csr_idx_type'(csr_chan.index) == CSR_KEY_HIGH ||
                                   csr_idx_type'(csr_chan.index) == CSR_KEY_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         nonce_high_ff <= '0;
         nonce_low_ff  <= '0;
      end else if (csr_fire) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_KEY_HIGH:   key_high_ff   <= csr_chan.data;
            CSR_KEY_LOW:    key_low_ff    <= csr_chan.data;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_chan.data;
            CSR_NONCE_LOW:  nonce_low_ff  <= csr_chan.data[31:0];
            default:        ;
         endcase
      end
   end

   actr_keysched u_keysched (
      .clock      (clock),
      .reset      (reset),
      .start      (key_write),
      .key        ({key_high_ff, key_low_ff}),
      .round_keys (round_keys),
      .status     (ks_status)
   );

   // Handshake: the whole pipe moves when the output slot is free or being drained
   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !ks_status.busy;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Block counter
   assign ctr_sel = req_chan.restart ? CTR_START : ctr_ff;
   assign cnt_sat = (req_chan.byte_count > COUNT_MAX) ? COUNT_MAX : req_chan.byte_count;

   always_comb begin
      ctr_in = ctr_ff;
      if (req_fire) begin
         ctr_in = (cnt_sat != '0) ? ctr_sel + CTR_START : ctr_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= CTR_START;
      end else begin
         ctr_ff <= ctr_in;
      end
   end

   // Round pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ROUNDS; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_fire;
         for (int k = 1; k < NUM_ROUNDS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_vld_ff <= vld_ff[NUM_ROUNDS-1];
      end
   end

   // Final round, keystream XOR and tail masking
   always_comb begin
      last_ks = aes_round(st_ff[NUM_ROUNDS-1], round_keys[NUM_ROUNDS], 1'b1);
      out_in  = last_ks ^ dat_ff[NUM_ROUNDS-1];
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (5'(i) >= cnt_ff[NUM_ROUNDS-1]) begin
            out_in[127-8*i -: 8] = 8'h00;
         end
      end
   end

   // Round pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0]  <= {nonce_high_ff, nonce_low_ff, ctr_sel} ^ round_keys[0];
         dat_ff[0] <= {req_chan.block_high, req_chan.block_low};
         cnt_ff[0] <= cnt_sat;
         for (int k = 1; k < NUM_ROUNDS; k++) begin
            st_ff[k]  <= aes_round(st_ff[k-1], round_keys[k], 1'b0);
            dat_ff[k] <= dat_ff[k-1];
            cnt_ff[k] <= cnt_ff[k-1];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.result_high = out_ff[127:64];
   assign rsp_chan.result_low  = out_ff[63:0];

`ifndef NO_ASSERTIONS
   a_ctr_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> ctr_ff == CTR_START)
      else $error("counter not reloaded by reset");
   a_ctr_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cnt_sat != '0) |=> ctr_ff == $past(ctr_sel) + CTR_START)
      else $error("counter did not advance");
   a_ctr_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cnt_sat == '0) |=> ctr_ff == $past(ctr_sel))
      else $error("counter moved on an empty beat");
   a_no_fire_busy: assert property (@(posedge clock) disable iff (reset)
      ks_status.busy |-> !req_fire)
      else $error("beat taken during key expansion");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> out_vld_ff && $stable(out_ff))
      else $error("result changed while stalled");
`endif
endmodule

[bench/tb_ifaces.sv]
`timescale 1ns / 1ps

// Test-side view of the channel interfaces lives in the design file; this file
// holds the beat records used by the stimulus and expected-result queues.
package tb_beat_pkg;
   typedef struct {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  byte_count;
      logic        restart;
   } data_beat_type;

   typedef struct {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } cipher_beat_type;
endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import actr_pkg::*;
   import tb_beat_pkg::*;

   localparam int PIPE_LAT  = 11;
   localparam int CYCLE_CAP = 400000;

   logic clock;
   logic reset;

   actr_req_if req_chan ();
   actr_rsp_if rsp_chan ();
   actr_csr_if csr_chan ();

   aes128_ctr_stream_cipher_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // predictor state
   logic [63:0] key_hi_m, key_lo_m, nonce_hi_m;
   logic [31:0] nonce_lo_m;
   logic [31:0] block_ctr_m = CTR_START;

   data_beat_type   pending_beats [$];
   cipher_beat_type expected_ciphertext [$];

   int  fail_count;
   int  cycle_count;
   bit  idle_on;
   bit  hold_rsp;
   int  hold_cycles;
   bit  done_sending;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gf_dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // AES-128 encryption of one block, bytes big-endian in the vector
   function automatic logic [127:0] aes128_block_encrypt(input logic [127:0] key,
                                                         input logic [127:0] pt);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w0, w1, w2, w3, tmp, rc, a0, a1, a2, a3, x;
      logic [127:0] r;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
      for (int i = 16; i < 176; i += 4) begin
         w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
         if (i % 16 == 0) begin
            tmp = w0;
            w0 = SBOX[w1] ^ rc; w1 = SBOX[w2]; w2 = SBOX[w3]; w3 = SBOX[tmp];
            rc = gf_dbl(rc);
         end
         rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
         rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
      end
      for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) t[k+4*c] = SBOX[s[k+4*((c+k)%4)]];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (rnd < 10) begin
               x = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
      return r;
   endfunction

   // ciphertext for one accepted beat; reloads the block counter on restart, advances it on a non-empty beat
   function automatic cipher_beat_type ctr_encrypt(input data_beat_type b);
      cipher_beat_type o;
      logic [127:0] ks, dat, res;
      int n;
      n = (b.byte_count > 16) ? 16 : int'(b.byte_count);
      if (b.restart) block_ctr_m = CTR_START;
      res = '0;
      if (n > 0) begin
         ks  = aes128_block_encrypt({key_hi_m, key_lo_m},
                                    {nonce_hi_m, nonce_lo_m, block_ctr_m});
         dat = {b.block_high, b.block_low};
         for (int i = 0; i < n; i++)
            res[127-8*i -: 8] = dat[127-8*i -: 8] ^ ks[127-8*i -: 8];
         block_ctr_m = block_ctr_m + 32'd1;
      end
      o.result_high = res[127:64];
      o.result_low  = res[63:0];
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic queue_beat(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic rs);
      data_beat_type b;
      b.block_high = hi; b.block_low = lo; b.byte_count = cnt; b.restart = rs;
      pending_beats.push_back(b);
   endtask

   // csr write through the handshake; model updated on acceptance
   task automatic csr_write(input csr_idx_type idx, input logic [63:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_KEY_HIGH:   key_hi_m   = val;
         CSR_KEY_LOW:    key_lo_m   = val;
         CSR_NONCE_HIGH: nonce_hi_m = val;
         CSR_NONCE_LOW:  nonce_lo_m = val[31:0];
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0 || expected_ciphertext.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // sender: offers queued beats, with random gaps while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) expected_ciphertext.push_back(ctr_encrypt(
            '{req_chan.block_high, req_chan.block_low, req_chan.byte_count,
              req_chan.restart}));
         if (pending_beats.size() != 0 && !(idle_on && $urandom_range(0, 99) < 12)) begin
            req_chan.valid      <= 1'b1;
            req_chan.block_high <= pending_beats[0].block_high;
            req_chan.block_low  <= pending_beats[0].block_low;
            req_chan.byte_count <= pending_beats[0].byte_count;
            req_chan.restart    <= pending_beats[0].restart;
            void'(pending_beats.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles    <= 0;
      end else if (hold_rsp && hold_cycles < 300) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles    <= hold_cycles + 1;
      end else begin
         rsp_chan.ready <= !(idle_on && $urandom_range(0, 99) < 12);
      end
   end

   // checker of ciphertext beats
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_ciphertext.size() == 0) begin
            $display("%0t: unexpected beat %h_%h", $time, rsp_chan.result_high,
                     rsp_chan.result_low);
            fail_count++;
         end else begin
            if (rsp_chan.result_high !== expected_ciphertext[0].result_high) begin
               $display("%0t: result_high expected %h actual %h", $time,
                        expected_ciphertext[0].result_high, rsp_chan.result_high);
               fail_count++;
            end
            if (rsp_chan.result_low !== expected_ciphertext[0].result_low) begin
               $display("%0t: result_low expected %h actual %h", $time,
                        expected_ciphertext[0].result_low, rsp_chan.result_low);
               fail_count++;
            end
            void'(expected_ciphertext.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [4:0] cnt;
      idle_on = 1'b1; hold_rsp = 1'b0;
      key_hi_m = '0; key_lo_m = '0; nonce_hi_m = '0; nonce_lo_m = '0;
      reset = 1'b1;
      csr_chan.valid = 1'b0; csr_chan.index = CSR_KEY_HIGH; csr_chan.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset key and nonce first, then FIPS-197 style key
      for (int c = 1; c <= 16; c++) queue_beat(rand64(), rand64(), 5'(c), c == 9);
      wait_drained();
      csr_write(CSR_KEY_HIGH, 64'h0001020304050607);
      csr_write(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      csr_write(CSR_NONCE_HIGH, '1);
      csr_write(CSR_NONCE_LOW, 64'h00000000ffffffff);
      queue_beat('0, '0, 5'd16, 1'b1);
      queue_beat('1, '1, 5'd16, 1'b0);
      queue_beat('1, '1, 5'd1, 1'b0);
      queue_beat('1, '1, 5'd15, 1'b1);
      wait_drained();

      // random phases, each with a new key and nonce (all-ones key in the last phase)
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_KEY_HIGH, (ph == 5) ? '1 : rand64());
         csr_write(CSR_KEY_LOW, (ph == 5) ? '1 : rand64());
         csr_write(CSR_NONCE_HIGH, rand64());
         csr_write(CSR_NONCE_LOW, {32'h0, $urandom});
         idle_on = (ph != 2);
         if (ph == 3) hold_rsp = 1'b1;
         for (int n = 0; n < 100; n++) begin
            cnt = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 16));
            queue_beat(rand64(), rand64(), cnt, $urandom_range(0, 19) == 0);
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
